// ===== rtl/core/lpwbe_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lpwbe_pkg
// Shared types and constants of the LED pulse-width bit encoder.
// ----------------------------------------------------------------------------
package lpwbe_pkg;

  localparam int unsigned PIXEL_W   = 24;
  localparam int unsigned TICK_W    = 16;
  localparam int unsigned RST_W     = 20;
  localparam int unsigned DUR_W     = 21;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_W     = 20;

  localparam logic [DUR_W-1:0] DUR_TOP = DUR_W'(1114110);

  // small queue between front and back, depth is a power of two
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_T0_HIGH     = 3'd0,
    REG_T0_LOW      = 3'd1,
    REG_T1_HIGH     = 3'd2,
    REG_T1_LOW      = 3'd3,
    REG_MIN_RESET   = 3'd4,
    REG_RESET_FLOOR = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic [TICK_W-1:0] t0_high;
    logic [TICK_W-1:0] t0_low;
    logic [TICK_W-1:0] t1_high;
    logic [TICK_W-1:0] t1_low;
    logic [RST_W-1:0]  min_reset;
    logic [RST_W-1:0]  reset_floor;
  } cfg_t;

  typedef struct packed {
    logic [PIXEL_W-1:0] pixel_word;
    logic               start_frame;
    logic [DUR_W-1:0]   reset_dur;
  } item_t;

endpackage

`default_nettype wire

// ===== rtl/core/led_pulse_width_bit_encoder_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// led_pulse_width_bit_encoder_top
// Pulse-width bit encoder for addressable LED strips.
// ----------------------------------------------------------------------------
// Each pixel beat becomes 2*BITS_PER_PIXEL line segments (level, ticks), MSB
// first, plus a leading low reset segment when start_frame is set; the final
// segment of a pixel carries last. The segment sequencer gives one segment per
// clock unless out_ready_i stalls it. A two-entry queue sits between the input
// stage and the sequencer, so pixels are taken while earlier ones are still
// going out, and the next pixel's first segment follows the previous last
// segment with no gap. Timing registers are written through the plain write
// port and should only change while no pixel is in flight.
module led_pulse_width_bit_encoder_top #(
  parameter int unsigned BITS_PER_PIXEL = 24
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [lpwbe_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [lpwbe_pkg::CFG_W-1:0]     cfg_data_i,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire logic [lpwbe_pkg::PIXEL_W-1:0]   pixel_word_i,
  input  wire logic                            start_frame_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic                                 level_o,
  output logic [lpwbe_pkg::DUR_W-1:0]          duration_ticks_o,
  output logic                                 last_o
);

  lpwbe_pkg::cfg_t  cfg_q;
  lpwbe_pkg::item_t push_item;
  lpwbe_pkg::item_t pop_item;
  logic             q_full;
  logic             q_push;
  logic             q_valid;
  logic             q_pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.t0_high     <= lpwbe_pkg::TICK_W'(40);
      cfg_q.t0_low      <= lpwbe_pkg::TICK_W'(85);
      cfg_q.t1_high     <= lpwbe_pkg::TICK_W'(80);
      cfg_q.t1_low      <= lpwbe_pkg::TICK_W'(45);
      cfg_q.min_reset   <= lpwbe_pkg::RST_W'(5000);
      cfg_q.reset_floor <= lpwbe_pkg::RST_W'(5000);
    end else if (cfg_we_i) begin
      case (lpwbe_pkg::reg_idx_e'(cfg_idx_i))
        lpwbe_pkg::REG_T0_HIGH:     cfg_q.t0_high     <= cfg_data_i[lpwbe_pkg::TICK_W-1:0];
        lpwbe_pkg::REG_T0_LOW:      cfg_q.t0_low      <= cfg_data_i[lpwbe_pkg::TICK_W-1:0];
        lpwbe_pkg::REG_T1_HIGH:     cfg_q.t1_high     <= cfg_data_i[lpwbe_pkg::TICK_W-1:0];
        lpwbe_pkg::REG_T1_LOW:      cfg_q.t1_low      <= cfg_data_i[lpwbe_pkg::TICK_W-1:0];
        lpwbe_pkg::REG_MIN_RESET:   cfg_q.min_reset   <= cfg_data_i[lpwbe_pkg::RST_W-1:0];
        lpwbe_pkg::REG_RESET_FLOOR: cfg_q.reset_floor <= cfg_data_i[lpwbe_pkg::RST_W-1:0];
        default: begin
        end
      endcase
    end
  end

  lpwbe_front u_front (
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .pixel_word_i  (pixel_word_i),
    .start_frame_i (start_frame_i),
    .cfg_i         (cfg_q),
    .q_full_i      (q_full),
    .q_push_o      (q_push),
    .q_item_o      (push_item)
  );

  lpwbe_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (push_item),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .item_o  (pop_item)
  );

  lpwbe_back #(
    .BITS_PER_PIXEL (BITS_PER_PIXEL)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg_q),
    .q_valid_i        (q_valid),
    .q_item_i         (pop_item),
    .q_pop_o          (q_pop),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .level_o          (level_o),
    .duration_ticks_o (duration_ticks_o),
    .last_o           (last_o)
  );

endmodule

`default_nettype wire

// ===== rtl/core/lpwbe_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lpwbe_front
// Accepts pixel beats and works out the reset segment length for each.
// ----------------------------------------------------------------------------
module lpwbe_front (
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [lpwbe_pkg::PIXEL_W-1:0] pixel_word_i,
  input  wire logic                          start_frame_i,
  input  wire lpwbe_pkg::cfg_t               cfg_i,
  input  wire logic                          q_full_i,
  output logic                               q_push_o,
  output lpwbe_pkg::item_t                   q_item_o
);

  logic [lpwbe_pkg::RST_W-1:0] base;
  logic [lpwbe_pkg::DUR_W-1:0] sum;

  always_comb begin
    base = (cfg_i.min_reset < cfg_i.reset_floor) ? cfg_i.reset_floor : cfg_i.min_reset;
    sum  = lpwbe_pkg::DUR_W'(base) + lpwbe_pkg::DUR_W'(cfg_i.t1_low);
  end

  assign in_ready_o = !q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

  always_comb begin
    q_item_o.pixel_word  = pixel_word_i;
    q_item_o.start_frame = start_frame_i;
    q_item_o.reset_dur   = (sum > lpwbe_pkg::DUR_TOP) ? lpwbe_pkg::DUR_TOP : sum;
  end

endmodule

`default_nettype wire

// ===== rtl/core/lpwbe_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lpwbe_queue
// Two-entry queue of classified pixel items between front and back.
// ----------------------------------------------------------------------------
module lpwbe_queue (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire lpwbe_pkg::item_t item_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic                  valid_o,
  output lpwbe_pkg::item_t      item_o
);

  lpwbe_pkg::item_t                mem_q [lpwbe_pkg::QUEUE_DEPTH];
  logic [lpwbe_pkg::QPTR_W-1:0]    wr_ptr_q, wr_ptr_d;
  logic [lpwbe_pkg::QPTR_W-1:0]    rd_ptr_q, rd_ptr_d;
  logic [lpwbe_pkg::QPTR_W:0]      count_q, count_d;

  assign full_o  = (count_q == (lpwbe_pkg::QPTR_W+1)'(lpwbe_pkg::QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign item_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("push into full queue");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o) else $error("pop from empty queue");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= (lpwbe_pkg::QPTR_W+1)'(lpwbe_pkg::QUEUE_DEPTH))
    else $error("queue count out of range");

endmodule

`default_nettype wire

// ===== rtl/core/lpwbe_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lpwbe_back
// Segment sequencer: turns one queued item into line segments, one per beat.
// ----------------------------------------------------------------------------
module lpwbe_back #(
  parameter int unsigned BITS_PER_PIXEL = 24
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire lpwbe_pkg::cfg_t               cfg_i,
  input  wire logic                          q_valid_i,
  input  wire lpwbe_pkg::item_t              q_item_i,
  output logic                               q_pop_o,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic                               level_o,
  output logic [lpwbe_pkg::DUR_W-1:0]        duration_ticks_o,
  output logic                               last_o
);

  localparam int unsigned IDX_W = $clog2(BITS_PER_PIXEL);

  logic                         busy_q;
  logic                         rst_pend_q;
  logic                         phase_q;     // 0 high half, 1 low half
  logic [IDX_W-1:0]             cnt_q;
  logic [BITS_PER_PIXEL-1:0]    sh_q;
  logic [lpwbe_pkg::DUR_W-1:0]  rdur_q;

  logic                         out_valid_q;
  logic                         level_q;
  logic [lpwbe_pkg::DUR_W-1:0]  dur_q;
  logic                         last_q;

  logic                         adv;
  logic                         last_seg;
  logic                         load;
  logic                         cur_bit;
  logic                         seg_level;
  logic [lpwbe_pkg::DUR_W-1:0]  seg_dur;

  assign adv      = !out_valid_q || out_ready_i;
  assign last_seg = busy_q && !rst_pend_q && phase_q && (cnt_q == '0);
  assign load     = q_valid_i && (!busy_q || (adv && last_seg));
  assign q_pop_o  = load;
  assign cur_bit  = sh_q[BITS_PER_PIXEL-1];

  always_comb begin
    if (rst_pend_q) begin
      seg_level = 1'b0;
      seg_dur   = rdur_q;
    end else if (!phase_q) begin
      seg_level = 1'b1;
      seg_dur   = lpwbe_pkg::DUR_W'(cur_bit ? cfg_i.t1_high : cfg_i.t0_high);
    end else begin
      seg_level = 1'b0;
      seg_dur   = lpwbe_pkg::DUR_W'(cur_bit ? cfg_i.t1_low : cfg_i.t0_low);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      rst_pend_q  <= 1'b0;
      phase_q     <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (adv) begin
        out_valid_q <= busy_q;
      end
      if (load) begin
        busy_q     <= 1'b1;
        rst_pend_q <= q_item_i.start_frame;
        phase_q    <= 1'b0;
        cnt_q      <= IDX_W'(BITS_PER_PIXEL - 1);
      end else if (adv && last_seg) begin
        busy_q <= 1'b0;
      end else if (adv && busy_q) begin
        if (rst_pend_q) begin
          rst_pend_q <= 1'b0;
        end else if (!phase_q) begin
          phase_q <= 1'b1;
        end else begin
          phase_q <= 1'b0;
          cnt_q   <= cnt_q - 1'b1;
        end
      end
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (load) begin
      sh_q   <= BITS_PER_PIXEL'(q_item_i.pixel_word);
      rdur_q <= q_item_i.reset_dur;
    end else if (adv && busy_q && !rst_pend_q && phase_q) begin
      sh_q <= sh_q << 1;
    end
    if (adv) begin
      level_q <= seg_level;
      dur_q   <= seg_dur;
      last_q  <= last_seg;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign level_o          = level_q;
  assign duration_ticks_o = dur_q;
  assign last_o           = last_q;

  a_last_is_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && last_q) |-> !level_q) else $error("last beat not a low segment");
  a_reset_seg_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && busy_q && rst_pend_q && !load) |=> (out_valid_q && !level_q && !last_q))
    else $error("reset segment malformed");
  a_idle_no_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && last_seg && !load) |=> !busy_q) else $error("sequencer did not go idle");

endmodule

`default_nettype wire
